[rtl/core/plist_pkg.sv]
// shared types, constants and codes of the positional list engine
package plist_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W       = $clog2(CAPACITY);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_POS   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ      = 3'd4;

  // status codes on the output channel
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ENTRY = 2'd3;

  typedef enum logic [2:0] {
    OP_INS_FRONT,
    OP_APPEND,
    OP_INS_POS,
    OP_DELETE,
    OP_READ
  } plist_op_e;

  // classified command as it sits in the queue
  typedef struct packed {
    plist_op_e               op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]        pos;
  } plist_cmd_t;

  typedef enum logic [1:0] {
    BK_CMD  = 2'b01,
    BK_READ = 2'b10
  } plist_bk_state_e;

endpackage

[rtl/core/plist_front.sv]
// front end: takes input words, decodes the action and normalises the position
module plist_front (
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [plist_pkg::ACT_W-1:0]          action_i,
  input  logic signed [plist_pkg::DATA_W-1:0]  value_i,
  input  logic [plist_pkg::POS_W-1:0]          position_i,
  output logic                                 push_o,
  output plist_pkg::plist_cmd_t                cmd_o,
  input  logic                                 q_ready_i
);

  logic cmd_known;

  always_comb begin
    cmd_known    = 1'b1;
    cmd_o.op     = plist_pkg::OP_READ;
    cmd_o.value  = value_i;
    // position zero behaves like position two
    cmd_o.pos    = (position_i == '0) ? plist_pkg::POS_W'(2) : position_i;
    case (action_i)
      plist_pkg::ACT_INS_FRONT: cmd_o.op = plist_pkg::OP_INS_FRONT;
      plist_pkg::ACT_APPEND:    cmd_o.op = plist_pkg::OP_APPEND;
      plist_pkg::ACT_INS_POS:   cmd_o.op = plist_pkg::OP_INS_POS;
      plist_pkg::ACT_DELETE:    cmd_o.op = plist_pkg::OP_DELETE;
      plist_pkg::ACT_READ:      cmd_o.op = plist_pkg::OP_READ;
      default:                  cmd_known = 1'b0;
    endcase
  end

  // unknown actions are taken and dropped
  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i & q_ready_i & cmd_known;

endmodule

[rtl/core/plist_queue.sv]
// short command queue between front and back end
module plist_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  plist_pkg::plist_cmd_t cmd_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output plist_pkg::plist_cmd_t cmd_o,
  input  logic                  pop_i
);

  plist_pkg::plist_cmd_t             slot_q [plist_pkg::QUEUE_DEPTH];
  logic [plist_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [plist_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [plist_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign ready_o = (cnt_q != plist_pkg::QCNT_W'(plist_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == plist_pkg::QPTR_W'(plist_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == plist_pkg::QPTR_W'(plist_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[rtl/core/plist_back.sv]
// back end: shift-chain list storage, command execution, readout and output word register
module plist_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_valid_i,
  input  plist_pkg::plist_cmd_t                cmd_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [plist_pkg::DATA_W-1:0]  value_out_o,
  output logic [plist_pkg::STATUS_W-1:0]       status_o,
  output logic                                 last_o
);

  localparam int unsigned Cap  = plist_pkg::CAPACITY;
  localparam int unsigned CntW = plist_pkg::CNT_W;

  logic signed [plist_pkg::DATA_W-1:0] entries_q [Cap];
  logic signed [plist_pkg::DATA_W-1:0] entries_d [Cap];
  logic [CntW-1:0]                     count_q, count_d;
  logic [plist_pkg::IDX_W-1:0]         rd_idx_q, rd_idx_d;
  plist_pkg::plist_bk_state_e          state_q, state_d;

  logic                                out_valid_q, out_valid_d;
  logic signed [plist_pkg::DATA_W-1:0] value_q, value_d;
  logic [plist_pkg::STATUS_W-1:0]      status_q, status_d;
  logic                                last_q, last_d;

  logic                                slot_free;
  logic                                emit;
  logic [plist_pkg::POS_W-1:0]         pos_m1;
  logic [CntW-1:0]                     ins_idx;
  logic [CntW-1:0]                     del_idx;
  logic                                del_miss;
  logic                                rd_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = (state_q == plist_pkg::BK_CMD) && slot_free && cmd_valid_i;
  assign pos_m1    = cmd_i.pos - 1'b1;
  assign del_miss  = (pos_m1 >= plist_pkg::POS_W'(count_q));
  assign del_idx   = pos_m1[CntW-1:0];
  assign rd_last   = ((CntW'(rd_idx_q) + 1'b1) == count_q);

  // insertion index, clipped to the end of the list
  always_comb begin
    case (cmd_i.op)
      plist_pkg::OP_INS_FRONT: ins_idx = '0;
      plist_pkg::OP_APPEND:    ins_idx = count_q;
      plist_pkg::OP_INS_POS: begin
        if (count_q == '0 || cmd_i.pos == plist_pkg::POS_W'(1)) begin
          ins_idx = '0;
        end else if (pos_m1 > plist_pkg::POS_W'(count_q)) begin
          ins_idx = count_q;
        end else begin
          ins_idx = pos_m1[CntW-1:0];
        end
      end
      default:                 ins_idx = '0;
    endcase
  end

  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    state_d   = state_q;
    emit      = 1'b0;
    value_d   = '0;
    status_d  = plist_pkg::ST_OK;
    last_d    = 1'b1;

    case (state_q)
      plist_pkg::BK_CMD: begin
        if (pop_o) begin
          case (cmd_i.op)
            plist_pkg::OP_INS_FRONT, plist_pkg::OP_APPEND, plist_pkg::OP_INS_POS: begin
              emit = 1'b1;
              if (count_q == CntW'(Cap)) begin
                status_d = plist_pkg::ST_FULL;
              end else begin
                for (int i = 1; i < Cap; i++) begin
                  if (CntW'(i) > ins_idx) begin
                    entries_d[i] = entries_q[i-1];
                  end
                end
                for (int i = 0; i < Cap; i++) begin
                  if (CntW'(i) == ins_idx) begin
                    entries_d[i] = cmd_i.value;
                  end
                end
                count_d = count_q + 1'b1;
              end
            end
            plist_pkg::OP_DELETE: begin
              emit = 1'b1;
              if (count_q == '0) begin
                status_d = plist_pkg::ST_EMPTY;
              end else if (del_miss) begin
                status_d = plist_pkg::ST_NO_ENTRY;
              end else begin
                for (int i = 0; i < Cap - 1; i++) begin
                  if (CntW'(i) >= del_idx) begin
                    entries_d[i] = entries_q[i+1];
                  end
                end
                count_d = count_q - 1'b1;
              end
            end
            plist_pkg::OP_READ: begin
              if (count_q == '0) begin
                emit     = 1'b1;
                status_d = plist_pkg::ST_EMPTY;
              end else begin
                rd_idx_d = '0;
                state_d  = plist_pkg::BK_READ;
              end
            end
            default: ;
          endcase
        end
      end
      plist_pkg::BK_READ: begin
        if (slot_free) begin
          emit     = 1'b1;
          value_d  = entries_q[rd_idx_q];
          last_d   = rd_last;
          rd_idx_d = rd_idx_q + 1'b1;
          if (rd_last) begin
            state_d = plist_pkg::BK_CMD;
          end
        end
      end
      default: state_d = plist_pkg::BK_CMD;
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_idx_q    <= '0;
      state_q     <= plist_pkg::BK_CMD;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
    if (emit) begin
      value_q  <= value_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

[rtl/core/positional_list_engine.sv]
// top level of the positional list engine: front decoder, command queue and back end
// path: a taken command word is stored in a queue slot, then executed by the back end
//   into the output register; a readout enters the read state before its first word
// throughput: one insert or delete per cycle while the output is taken and no readout
//   runs; a readout holds the back end until it has emitted every stored entry
// reset: the entry count, queue and output valid clear at once; list storage is not cleared
module positional_list_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [plist_pkg::ACT_W-1:0]          action_i,
  input  logic signed [plist_pkg::DATA_W-1:0]  value_i,
  input  logic [plist_pkg::POS_W-1:0]          position_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [plist_pkg::DATA_W-1:0]  value_out_o,
  output logic [plist_pkg::STATUS_W-1:0]       status_o,
  output logic                                 last_o
);

  // classified command from the front end into the queue
  logic                  push;
  plist_pkg::plist_cmd_t front_cmd;
  logic                  q_ready;

  // queue head towards the back end
  logic                  q_valid;
  plist_pkg::plist_cmd_t head_cmd;
  logic                  pop;

  // decode the action, fold position zero onto two, drop unknown actions
  plist_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .value_i    (value_i),
    .position_i (position_i),
    .push_o     (push),
    .cmd_o      (front_cmd),
    .q_ready_i  (q_ready)
  );

  // two-entry queue so the front keeps taking words, until the queue is full, while the back end
  // is stalled on the output or busy with a readout
  plist_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  // list storage as a shift chain; inserts and deletes shift the chain in a single update,
  // readout walks the entries one a cycle into the output register while the output is taken
  plist_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_out_o (value_out_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
